[rtl/vppu_pkg.sv]
// ----------------------------------------------------------------------------
// vppu_pkg
// shared types, codes and timing constants of the video ppu register block
// ----------------------------------------------------------------------------
`default_nettype none

package vppu_pkg;

  // store sizes
  localparam int PATTERN_BYTES   = 8192;
  localparam int NAMETABLE_BYTES = 2048;
  localparam int PALETTE_BYTES   = 32;

  // dot timing
  localparam logic [8:0] DOTS_PER_LINE   = 9'd341;
  localparam logic [8:0] LINES_PER_FRAME = 9'd262;
  localparam logic [8:0] VBLANK_LINE     = 9'd241;
  localparam logic [8:0] VBLANK_END_LINE = 9'd20;

  // item kinds
  localparam logic [1:0] KIND_REG_RD = 2'd0;
  localparam logic [1:0] KIND_REG_WR = 2'd1;
  localparam logic [1:0] KIND_MEM_RD = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // cpu-side register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // bits of control and status bytes
  localparam int CTRL_INC32_BIT  = 2;
  localparam int CTRL_NMI_BIT    = 7;
  localparam int STATUS_VBL_BIT  = 7;
  localparam logic [7:0] STATUS_RESET = 8'h10;

  // configuration register map
  localparam logic [2:0] CFG_ADDR_MIRROR = 3'd0;

  // store select codes
  localparam logic [1:0] STORE_PAT  = 2'd0;
  localparam logic [1:0] STORE_NAME = 2'd1;
  localparam logic [1:0] STORE_PAL  = 2'd2;

  // video memory request, one per word at most
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [13:0] addr;
    logic [7:0]  wdata;
  } vppu_mem_req_t;

  // one result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_pulse;
    logic       vblank_active;
  } vppu_res_t;

endpackage

`default_nettype wire

[rtl/vppu_if.sv]
// ----------------------------------------------------------------------------
// vppu channel interfaces
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface vppu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  reg_index;
  logic [7:0]  write_data;
  logic [15:0] mem_address;

  modport source (output valid, kind, reg_index, write_data, mem_address, input ready);
  modport sink   (input valid, kind, reg_index, write_data, mem_address, output ready);
endinterface

interface vppu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi_pulse;
  logic       vblank_active;

  modport source (output valid, read_data, nmi_pulse, vblank_active, input ready);
  modport sink   (input valid, read_data, nmi_pulse, vblank_active, output ready);
endinterface

`default_nettype wire

[rtl/video_ppu_register_and_timing.sv]
// ----------------------------------------------------------------------------
// video_ppu_register_and_timing
// ppu cpu register interface, video memory stores and dot/line timing
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the sink takes results; any mix of
//   register, memory and tick words; each result is registered at the store
//   read port, then in the result queue, and waits while the sink stalls
// reset: synchronous rst_n clears control bytes, toggles, scroll and pointer,
//   status to 0x10, line 241, dot 0, mirroring horizontal; the stores are not
//   cleared and hold garbage until written, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module video_ppu_register_and_timing
  import vppu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  vppu_in_if.sink          in_ch,
  vppu_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          acc;
  logic          room;
  logic          mirror_r;
  vppu_mem_req_t mem_req;
  vppu_res_t     reg_res;
  logic [7:0]    mem_rd_data;

  // word in flight while the store read completes
  logic          s1_v_r;
  logic          s1_mem_r;
  vppu_res_t     s1_res_r;
  vppu_res_t     s1_res;

  // apb config: single mirroring register at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr == CFG_ADDR_MIRROR) ? {31'd0, mirror_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_MIRROR) begin
      mirror_r <= pwdata[0];
    end
  end

  // accept whenever the queue keeps a slot for this word
  assign in_ch.ready = room;
  assign acc         = in_ch.valid && in_ch.ready;

  vppu_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .kind        (in_ch.kind),
    .reg_index   (in_ch.reg_index),
    .write_data  (in_ch.write_data),
    .mem_address (in_ch.mem_address),
    .mem_req     (mem_req),
    .res         (reg_res)
  );

  // writes land at the accept edge, so a read on the next word sees them
  vppu_vram u_vram (
    .clk         (clk),
    .mirror_mode (mirror_r),
    .mem_req     (mem_req),
    .rd_data     (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mem_r <= mem_req.rd;
      s1_res_r <= reg_res;
    end
  end

  // memory reads take their byte from the store port
  always_comb begin
    s1_res = s1_res_r;
    if (s1_mem_r) s1_res.read_data = mem_rd_data;
  end

  vppu_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_v_r),
    .push_res (s1_res),
    .room     (room),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[rtl/vppu_regs.sv]
// ----------------------------------------------------------------------------
// vppu_regs
// cpu register file, write toggles and dot/line timing; issues memory requests
// ----------------------------------------------------------------------------
`default_nettype none

module vppu_regs
  import vppu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [1:0]    kind,
  input  wire logic [2:0]    reg_index,
  input  wire logic [7:0]    write_data,
  input  wire logic [15:0]   mem_address,
  output vppu_mem_req_t      mem_req,
  output vppu_res_t          res
);

  logic [7:0]  ctrl1_r, ctrl1_nxt;
  logic [7:0]  ctrl2_r, ctrl2_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        scroll_tgl_r, scroll_tgl_nxt;
  logic        addr_tgl_r, addr_tgl_nxt;
  logic [15:0] scroll_r, scroll_nxt;
  logic [15:0] vptr_r, vptr_nxt;
  logic [8:0]  line_r, line_nxt;
  logic [8:0]  dot_r, dot_nxt;
  logic [8:0]  dot_inc;
  logic [8:0]  line_inc;

  assign dot_inc  = dot_r + 9'd1;
  assign line_inc = line_r + 9'd1;

  always_comb begin
    ctrl1_nxt      = ctrl1_r;
    ctrl2_nxt      = ctrl2_r;
    status_nxt     = status_r;
    scroll_tgl_nxt = scroll_tgl_r;
    addr_tgl_nxt   = addr_tgl_r;
    scroll_nxt     = scroll_r;
    vptr_nxt       = vptr_r;
    line_nxt       = line_r;
    dot_nxt        = dot_r;
    mem_req.wr     = 1'b0;
    mem_req.rd     = 1'b0;
    mem_req.addr   = vptr_r[13:0];
    mem_req.wdata  = write_data;
    res.read_data  = 8'h00;
    res.nmi_pulse  = 1'b0;
    if (acc) begin
      unique case (kind)
        KIND_REG_RD: begin
          if (reg_index == REG_STATUS) begin
            res.read_data              = status_r;
            status_nxt[STATUS_VBL_BIT] = 1'b0;
          end
        end
        KIND_REG_WR: begin
          unique case (reg_index)
            REG_CTRL: ctrl1_nxt = write_data;
            REG_MASK: ctrl2_nxt = write_data;
            REG_SCROLL: begin
              // high byte first, low byte second
              scroll_nxt     = scroll_tgl_r ? {scroll_r[15:8], write_data}
                                            : {write_data, scroll_r[7:0]};
              scroll_tgl_nxt = ~scroll_tgl_r;
            end
            REG_ADDR: begin
              vptr_nxt     = addr_tgl_r ? {vptr_r[15:8], write_data}
                                        : {write_data, vptr_r[7:0]};
              addr_tgl_nxt = ~addr_tgl_r;
            end
            REG_DATA: begin
              mem_req.wr = 1'b1;
              vptr_nxt   = vptr_r + (ctrl1_r[CTRL_INC32_BIT] ? 16'd32 : 16'd1);
            end
            default: ;
          endcase
        end
        KIND_MEM_RD: begin
          mem_req.rd   = 1'b1;
          mem_req.addr = mem_address[13:0];
        end
        KIND_TICK: begin
          dot_nxt = dot_inc;
          if (dot_inc >= DOTS_PER_LINE) begin
            dot_nxt  = 9'd0;
            line_nxt = line_inc;
            if (line_inc == VBLANK_END_LINE) begin
              status_nxt[STATUS_VBL_BIT] = 1'b0;
            end else if (line_inc == VBLANK_LINE) begin
              status_nxt[STATUS_VBL_BIT] = 1'b1;
              res.nmi_pulse              = ctrl1_r[CTRL_NMI_BIT];
            end else if (line_inc >= LINES_PER_FRAME) begin
              line_nxt = 9'd0;
            end
          end
        end
        default: ;
      endcase
    end
    res.vblank_active = status_nxt[STATUS_VBL_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r      <= 8'h00;
      ctrl2_r      <= 8'h00;
      status_r     <= STATUS_RESET;
      scroll_tgl_r <= 1'b0;
      addr_tgl_r   <= 1'b0;
      scroll_r     <= 16'h0000;
      vptr_r       <= 16'h0000;
      line_r       <= VBLANK_LINE;
      dot_r        <= 9'd0;
    end else begin
      ctrl1_r      <= ctrl1_nxt;
      ctrl2_r      <= ctrl2_nxt;
      status_r     <= status_nxt;
      scroll_tgl_r <= scroll_tgl_nxt;
      addr_tgl_r   <= addr_tgl_nxt;
      scroll_r     <= scroll_nxt;
      vptr_r       <= vptr_nxt;
      line_r       <= line_nxt;
      dot_r        <= dot_nxt;
    end
  end

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r < DOTS_PER_LINE) else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r < LINES_PER_FRAME) else $error("line counter out of range");

  a_nmi_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    res.nmi_pulse |=> status_r[STATUS_VBL_BIT]) else $error("nmi without vblank");

endmodule

`default_nettype wire

[rtl/vppu_vram.sv]
// ----------------------------------------------------------------------------
// vppu_vram
// pattern, nametable and palette stores behind the mirrored address map
// ----------------------------------------------------------------------------
`default_nettype none

module vppu_vram
  import vppu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          mirror_mode,
  input  wire vppu_mem_req_t mem_req,
  output logic [7:0]         rd_data
);

  logic [7:0] pat_mem  [PATTERN_BYTES];
  logic [7:0] name_mem [NAMETABLE_BYTES];
  logic [7:0] pal_mem  [PALETTE_BYTES];

  logic [1:0]  sel;
  logic [1:0]  sel_r;
  logic        bank;
  logic [10:0] name_idx;
  logic [7:0]  pat_q_r, name_q_r, pal_q_r;

  always_comb begin
    if (!mem_req.addr[13]) begin
      sel = STORE_PAT;
    end else if (mem_req.addr[13:8] == 6'h3F) begin
      sel = STORE_PAL;
    end else begin
      sel = STORE_NAME;
    end
  end

  // vertical: tables 0,2 / 1,3 share; horizontal: tables 0,1 / 2,3 share
  assign bank     = mirror_mode ? mem_req.addr[10] : mem_req.addr[11];
  assign name_idx = {bank, mem_req.addr[9:0]};

  always_ff @(posedge clk) begin
    if (mem_req.wr && sel == STORE_PAT) pat_mem[mem_req.addr[12:0]] <= mem_req.wdata;
    if (mem_req.rd && sel == STORE_PAT) pat_q_r <= pat_mem[mem_req.addr[12:0]];
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr && sel == STORE_NAME) name_mem[name_idx] <= mem_req.wdata;
    if (mem_req.rd && sel == STORE_NAME) name_q_r <= name_mem[name_idx];
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr && sel == STORE_PAL) pal_mem[mem_req.addr[4:0]] <= mem_req.wdata;
    if (mem_req.rd && sel == STORE_PAL) pal_q_r <= pal_mem[mem_req.addr[4:0]];
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd) sel_r <= sel;
  end

  always_comb begin
    unique case (sel_r)
      STORE_PAT:  rd_data = pat_q_r;
      STORE_NAME: rd_data = name_q_r;
      STORE_PAL:  rd_data = pal_q_r;
      default:    rd_data = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

[rtl/vppu_outq.sv]
// ----------------------------------------------------------------------------
// vppu_outq
// two-word result queue that decouples the pipeline from the result sink
// ----------------------------------------------------------------------------
`default_nettype none

module vppu_outq
  import vppu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire vppu_res_t push_res,
  output logic           room,
  vppu_out_if.source     out_ch
);

  vppu_res_t  q_r [2];
  logic       head_r, tail_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] cnt_ahead;

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.read_data     = q_r[head_r].read_data;
  assign out_ch.nmi_pulse     = q_r[head_r].nmi_pulse;
  assign out_ch.vblank_active = q_r[head_r].vblank_active;
  assign pop                  = out_ch.valid && out_ch.ready;

  // occupancy once the word now in flight has landed; keep one slot spare
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};
  assign cnt_ahead = {1'b0, cnt_r} + {2'b00, push} - {2'b00, pop};
  assign room      = (cnt_ahead <= 3'd1);

  always_ff @(posedge clk) begin
    if (push) q_r[tail_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) tail_r <= ~tail_r;
      if (pop)  head_r <= ~head_r;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2 && !pop)) else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("result queue count out of range");

endmodule

`default_nettype wire

[test/vppu_checker.sv]
// ----------------------------------------------------------------------------
// vppu_checker
// predicts every result word of the ppu register block and compares it
// ----------------------------------------------------------------------------
// watches the input channel, the result channel and the apb port; keeps its
// own copy of registers, stores and dot timing, queues one expected word per
// accepted input word and checks result words in order
// ----------------------------------------------------------------------------
`default_nettype none

module vppu_checker
  import vppu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  vppu_in_if               in_ch,
  vppu_out_if              out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               nmi_count,
  output int               vblank_reads
);

  logic        mirror_v;
  logic [7:0]  ctrl_one;
  logic [7:0]  ctrl_two;
  logic [7:0]  status_b;
  logic        scroll_tog;
  logic        addr_tog;
  logic [15:0] scroll_w;
  logic [15:0] vptr;
  logic [8:0]  line_n;
  logic [8:0]  dot_n;

  logic [7:0] pat_mem  [PATTERN_BYTES];
  logic [7:0] name_mem [NAMETABLE_BYTES];
  logic [7:0] pal_mem  [PALETTE_BYTES];

  vppu_res_t results_due [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    nmi_count    = 0;
    vblank_reads = 0;
  end

  // mirrored video address map
  task automatic vram_slot(input logic [15:0] addr, output logic [1:0] sel, output int idx);
    logic [13:0] a;
    logic [1:0]  tbl;
    logic        bank;
    a = addr[13:0];
    if (a < 14'h2000) begin
      sel = STORE_PAT;
      idx = int'(a[12:0]);
    end else if (a < 14'h3F00) begin
      tbl  = a[11:10];
      bank = mirror_v ? tbl[0] : tbl[1];
      sel  = STORE_NAME;
      idx  = int'({bank, a[9:0]});
    end else begin
      sel = STORE_PAL;
      idx = int'(a[4:0]);
    end
  endtask

  task automatic ppu_result_for(input logic [1:0] k, input logic [2:0] ri,
                                input logic [7:0] wd, input logic [15:0] ma,
                                output vppu_res_t r);
    logic [1:0] sel;
    int         idx;
    r = '0;
    case (k)
      KIND_REG_RD: begin
        if (ri == REG_STATUS) begin
          r.read_data = status_b;
          if (status_b[STATUS_VBL_BIT]) vblank_reads++;
          status_b[STATUS_VBL_BIT] = 1'b0;
        end
      end
      KIND_REG_WR: begin
        case (ri)
          REG_CTRL: ctrl_one = wd;
          REG_MASK: ctrl_two = wd;
          REG_SCROLL: begin
            if (scroll_tog) scroll_w[7:0] = wd;
            else scroll_w[15:8] = wd;
            scroll_tog = ~scroll_tog;
          end
          REG_ADDR: begin
            if (addr_tog) vptr[7:0] = wd;
            else vptr[15:8] = wd;
            addr_tog = ~addr_tog;
          end
          REG_DATA: begin
            vram_slot(vptr, sel, idx);
            case (sel)
              STORE_PAT:  pat_mem[idx]  = wd;
              STORE_NAME: name_mem[idx] = wd;
              default:    pal_mem[idx]  = wd;
            endcase
            vptr = vptr + (ctrl_one[CTRL_INC32_BIT] ? 16'd32 : 16'd1);
          end
          default: ;
        endcase
      end
      KIND_MEM_RD: begin
        vram_slot(ma, sel, idx);
        case (sel)
          STORE_PAT:  r.read_data = pat_mem[idx];
          STORE_NAME: r.read_data = name_mem[idx];
          default:    r.read_data = pal_mem[idx];
        endcase
      end
      default: begin
        dot_n = dot_n + 9'd1;
        if (dot_n >= DOTS_PER_LINE) begin
          dot_n  = '0;
          line_n = line_n + 9'd1;
          if (line_n == VBLANK_END_LINE) begin
            status_b[STATUS_VBL_BIT] = 1'b0;
          end else if (line_n == VBLANK_LINE) begin
            status_b[STATUS_VBL_BIT] = 1'b1;
            if (ctrl_one[CTRL_NMI_BIT]) r.nmi_pulse = 1'b1;
          end else if (line_n >= LINES_PER_FRAME) begin
            line_n = '0;
          end
        end
      end
    endcase
    r.vblank_active = status_b[STATUS_VBL_BIT];
  endtask

  always @(posedge clk) begin
    vppu_res_t want;
    vppu_res_t got;
    if (!rst_n) begin
      mirror_v   = 1'b0;
      ctrl_one   = '0;
      ctrl_two   = '0;
      status_b   = STATUS_RESET;
      scroll_tog = 1'b0;
      addr_tog   = 1'b0;
      scroll_w   = '0;
      vptr       = '0;
      line_n     = VBLANK_LINE;
      dot_n      = '0;
      results_due.delete();
    end else begin
      if (psel && penable && pready && paddr == CFG_ADDR_MIRROR) begin
        if (pwrite) begin
          mirror_v = pwdata[0];
        end else if (prdata !== {31'b0, mirror_v}) begin
          $error("mirror_mode expected %0h got %0h", mirror_v, prdata);
          fail_count++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: read_data %02h", out_ch.read_data);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          got  = '{out_ch.read_data, out_ch.nmi_pulse, out_ch.vblank_active};
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %02h got %02h", want.read_data, got.read_data);
            fail_count++;
          end
          if (got.nmi_pulse !== want.nmi_pulse) begin
            $error("nmi_pulse expected %0b got %0b", want.nmi_pulse, got.nmi_pulse);
            fail_count++;
          end
          if (got.vblank_active !== want.vblank_active) begin
            $error("vblank_active expected %0b got %0b", want.vblank_active,
                   got.vblank_active);
            fail_count++;
          end
          if (got.nmi_pulse === 1'b1) nmi_count++;
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        ppu_result_for(in_ch.kind, in_ch.reg_index, in_ch.write_data, in_ch.mem_address,
                       want);
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for video_ppu_register_and_timing
// ----------------------------------------------------------------------------
// a short directed pass over every register and the mirrored address map,
// then random register/memory/tick traffic under both mirroring modes with
// sparse dot ticks in between; a separate checker predicts and compares
// every result word
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import vppu_pkg::*;

  // registers with no name in the package, both ignored on write
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;

  localparam int RANDOM_WORDS  = 1620;
  localparam int MIRROR_PERIOD = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int VRAM_SLOTS    = PATTERN_BYTES + NAMETABLE_BYTES + PALETTE_BYTES;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int checked;
  int nmi_count;
  int vblank_reads;

  vppu_in_if  in_ch ();
  vppu_out_if out_ch ();

  video_ppu_register_and_timing u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vppu_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .nmi_count    (nmi_count),
    .vblank_reads (vblank_reads)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus-side bookkeeping: just enough of the pointer and the mirroring
  // to know which video addresses have been written, so a memory read never
  // lands on an entry that holds garbage
  // ---------------------------------------------------------------------------
  logic        sh_mirror;
  logic        sh_inc32;
  logic        sh_addr_tog;
  logic [15:0] sh_vptr;
  bit          written [VRAM_SLOTS];
  logic [13:0] written_addrs [$];

  int  words_sent  = 0;
  int  ticks_sent  = 0;
  int  burst_left  = 0;
  int  quiet_cycles = 0;
  bit  hold_req    = 1'b0;
  bit  hold_done   = 1'b0;

  // physical slot behind a 14-bit video address under the current mirroring
  function automatic int slot_of(logic [13:0] a);
    logic [1:0] tbl;
    tbl = a[11:10];
    if (a < 14'h2000) return int'(a[12:0]);
    if (a < 14'h3F00)
      return PATTERN_BYTES + int'({sh_mirror ? tbl[0] : tbl[1], a[9:0]});
    return PATTERN_BYTES + NAMETABLE_BYTES + int'(a[4:0]);
  endfunction

  // one word on the input channel; the sender runs in bursts with gaps
  // between them, and a burst of gap zero gives stretches with no idling
  task automatic send_word(input logic [1:0] k, input logic [2:0] ri,
                           input logic [7:0] wd, input logic [15:0] ma);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    if (k == KIND_TICK) ticks_sent++;
    if (k == KIND_REG_WR) begin
      case (ri)
        REG_CTRL: sh_inc32 = wd[CTRL_INC32_BIT];
        REG_ADDR: begin
          if (sh_addr_tog) sh_vptr[7:0] = wd;
          else sh_vptr[15:8] = wd;
          sh_addr_tog = ~sh_addr_tog;
        end
        REG_DATA: begin
          written[slot_of(sh_vptr[13:0])] = 1'b1;
          written_addrs.push_back(sh_vptr[13:0]);
          sh_vptr = sh_vptr + (sh_inc32 ? 16'd32 : 16'd1);
        end
        default: ;
      endcase
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.reg_index   <= ri;
    in_ch.write_data  <= wd;
    in_ch.mem_address <= ma;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // video read of something already written, often through a mirror alias;
  // falls back to a status read when nothing suitable turns up
  task automatic read_written_vram();
    logic [13:0] a;
    for (int tries = 0; tries < 6; tries++) begin
      if (written_addrs.size() == 0) break;
      a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      if (a >= 14'h2000 && a < 14'h3F00) begin
        // 0x3000 range repeats 0x2000, and two tables share each bank
        if ($urandom_range(0, 1) == 1) a[12] = ~a[12];
        if ($urandom_range(0, 1) == 1) begin
          if (sh_mirror) a[11] = ~a[11];
          else a[10] = ~a[10];
        end
      end else if (a >= 14'h3F00) begin
        a[7:5] = 3'($urandom);
      end
      if (written[slot_of(a)]) begin
        send_word(KIND_MEM_RD, 3'($urandom), 8'($urandom), {2'($urandom), a});
        return;
      end
    end
    send_word(KIND_REG_RD, REG_STATUS, 8'($urandom), 16'($urandom));
  endtask

  // stop offering and wait until every expected result word is back
  task automatic wait_results_in();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    // a little slack before the next step
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  // apb write of the mirroring register followed by a read back
  task automatic write_mirroring(input logic m);
    wait_results_in();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_MIRROR;
    pwdata  <= {31'b0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sh_mirror = m;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall mode redrawn periodically, one of four, plus one long
  // hold-off so the block fills up and pushes back on the input
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cyc % 5 != 0);
      endcase
    end
  end

  // watchdog: cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [7:0] d;
    logic [7:0] hi;
    int         n;
    int         rand_end;
    int         next_cfg;
    int         hold_at;

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_REG_RD;
    in_ch.reg_index   = REG_CTRL;
    in_ch.write_data  = '0;
    in_ch.mem_address = '0;
    sh_mirror         = 1'b0;
    sh_inc32          = 1'b0;
    sh_addr_tog       = 1'b0;
    sh_vptr           = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mirroring(1'b0);

    // --- directed part, horizontal mirroring ---
    // status after reset: accepting-writes bit only, vblank clear
    send_word(KIND_REG_RD, REG_STATUS, 8'h00, 16'h0000);
    // every other register reads as zero
    for (int i = 0; i < 8; i++)
      if (3'(i) != REG_STATUS) send_word(KIND_REG_RD, 3'(i), 8'hFF, 16'hFFFF);
    // writes to status and the two sprite ports go nowhere
    send_word(KIND_REG_WR, REG_STATUS, 8'hFF, 16'hFFFF);
    send_word(KIND_REG_WR, REG_OAM_ADDR, 8'hFF, 16'h0000);
    send_word(KIND_REG_WR, REG_OAM_DATA, 8'hFF, 16'hFFFF);
    // pointer to 0xffff high byte first, store at the top of the palette,
    // pointer wraps to zero and the next store lands in pattern byte 0
    send_word(KIND_REG_WR, REG_CTRL, 8'h00, 16'h0000);
    send_word(KIND_REG_WR, REG_ADDR, 8'hFF, 16'h0000);
    send_word(KIND_REG_WR, REG_ADDR, 8'hFF, 16'h0000);
    send_word(KIND_REG_WR, REG_DATA, 8'hA5, 16'h0000);
    send_word(KIND_REG_WR, REG_DATA, 8'h5A, 16'h0000);
    send_word(KIND_MEM_RD, REG_DATA, 8'h00, 16'hFFFF);
    send_word(KIND_MEM_RD, REG_CTRL, 8'h00, 16'h0000);
    // step of 32 across the edge of table 0 into table 1
    send_word(KIND_REG_WR, REG_CTRL, 8'h04, 16'h0000);
    send_word(KIND_REG_WR, REG_ADDR, 8'h23, 16'h0000);
    send_word(KIND_REG_WR, REG_ADDR, 8'hE0, 16'h0000);
    send_word(KIND_REG_WR, REG_DATA, 8'hFF, 16'h0000);
    send_word(KIND_REG_WR, REG_DATA, 8'h00, 16'h0000);
    // horizontal: table 1 shares bank 0 with table 0, 0x3400 mirrors 0x2400
    send_word(KIND_MEM_RD, REG_CTRL, 8'h00, 16'h27E0);
    send_word(KIND_MEM_RD, REG_CTRL, 8'h00, 16'h3400);
    // scroll port, high byte then low byte
    send_word(KIND_REG_WR, REG_SCROLL, 8'h00, 16'h0000);
    send_word(KIND_REG_WR, REG_SCROLL, 8'hFF, 16'h0000);
    send_word(KIND_TICK, REG_CTRL, 8'h00, 16'h0000);

    // vertical: table 2 now shares bank 0 with table 0
    write_mirroring(1'b1);
    send_word(KIND_MEM_RD, REG_CTRL, 8'h00, 16'h2BE0);
    send_word(KIND_MEM_RD, REG_CTRL, 8'h00, 16'hEBE0);

    // --- random part ---
    rand_end = words_sent + RANDOM_WORDS;
    next_cfg = words_sent + MIRROR_PERIOD;
    hold_at  = words_sent + $urandom_range(300, 1200);
    while (words_sent < rand_end) begin
      if (words_sent >= next_cfg) begin
        write_mirroring(~sh_mirror);
        next_cfg = words_sent + MIRROR_PERIOD;
      end
      if (!hold_req && words_sent >= hold_at) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // address setup, a run of data stores, then reads of what was stored
          if (sh_addr_tog) send_word(KIND_REG_WR, REG_ADDR, 8'($urandom), 16'($urandom));
          case ($urandom_range(0, 3))
            0:       hi = 8'($urandom_range(8'h00, 8'h1F));
            1:       hi = 8'($urandom_range(8'h20, 8'h3E));
            2:       hi = {2'($urandom), 6'h3F};
            default: hi = 8'($urandom);
          endcase
          send_word(KIND_REG_WR, REG_ADDR, hi, 16'($urandom));
          send_word(KIND_REG_WR, REG_ADDR, 8'($urandom), 16'($urandom));
          if ($urandom_range(0, 2) == 0)
            send_word(KIND_REG_WR, REG_CTRL, 8'($urandom), 16'($urandom));
          n = $urandom_range(1, 8);
          repeat (n) send_word(KIND_REG_WR, REG_DATA, 8'($urandom), 16'($urandom));
          n = $urandom_range(1, 4);
          repeat (n) read_written_vram();
        end
        4, 5: begin
          n = $urandom_range(1, 30);
          repeat (n) send_word(KIND_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
        end
        6: send_word(KIND_REG_RD, 3'($urandom), 8'($urandom), 16'($urandom));
        7: read_written_vram();
        8: send_word(KIND_REG_WR, 3'($urandom), 8'($urandom), 16'($urandom));
        default: begin
          // any kind at all; memory reads stay on written entries
          d = 8'($urandom);
          if (d[1:0] == KIND_MEM_RD) read_written_vram();
          else send_word(d[1:0], 3'($urandom), 8'($urandom), 16'($urandom));
        end
      endcase
    end

    // --- wind down and verdict ---
    wait_results_in();
    repeat (8) @(negedge clk);
    $display("ran %0d words, %0d of them dot ticks, under both mirroring modes",
             words_sent, ticks_sent);
    $display("compared %0d results: %0d nmi pulses, %0d status reads in vblank",
             checked, nmi_count, vblank_reads);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
